// ===== design/uks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uks_pkg
// Shared codes and types of the unique-key stack: action and status codes,
// the stored key/data pair and the fixed field widths.
// ----------------------------------------------------------------------------
package uks_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 5;

    // action codes; the unused code behaves as a look
    localparam logic [1:0] ACT_LOOK = 2'd0;
    localparam logic [1:0] ACT_PUSH = 2'd1;
    localparam logic [1:0] ACT_POP  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } uks_pair_t;

endpackage

// ===== design/uks_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uks_ram
// Generic single-clock RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module uks_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/unique_key_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_key_stack
// LIFO of key/data pairs, at most DEPTH entries, with a duplicate-key check
// on every push. Look, push and pop each return one result item.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready  | action, item_key, item_value
//  m_      | out       | m_valid / m_ready  | status, top_key, top_value,
//          |           |                    | is_empty, entry_count
//
//  Steps per item; the block accepts the next item only when idle again:
//    push of a new key : the key scan reads one stored key per cycle from
//                        the pair RAM's single read port, then the pair is
//                        written; on an empty stack the write comes at once
//    rejected push     : when full, the scan and then a read of the top
//                        entry; a duplicate ends the scan at its match,
//                        followed by a read of the top entry
//    look or pop       : one RAM read of the top entry; none when empty
//  Reset (aresetn low, synchronous) empties the stack; the RAM contents are
//  not cleared, entries at or above the fill level are never read.
//  A result waiting on m_ready does not block the next accept; the block
//  stalls only when a new result is ready while the output still holds one.
// ----------------------------------------------------------------------------
module unique_key_stack
    import uks_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_action,
    input  logic signed [KEY_W-1:0] s_item_key,
    input  logic signed [VAL_W-1:0] s_item_value,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_status,
    output logic signed [KEY_W-1:0] m_top_key,
    output logic signed [VAL_W-1:0] m_top_value,
    output logic                    m_is_empty,
    output logic [CNT_W-1:0]        m_entry_count
);

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int PAIR_W = $bits(uks_pair_t);

    localparam logic [CW-1:0] FILL_MAX = CW'(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_TOP_RD = 3'd2;
    localparam logic [2:0] S_TOP_WT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic          m_valid_reg, m_valid_next;

    // held item and pending result (payload)
    logic [1:0]              act_reg, act_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [1:0]              res_status_reg, res_status_next;
    logic signed [KEY_W-1:0] res_key_reg, res_key_next;
    logic signed [VAL_W-1:0] res_val_reg, res_val_next;

    // output registers (payload)
    logic [1:0]              m_status_reg;
    logic signed [KEY_W-1:0] m_top_key_reg;
    logic signed [VAL_W-1:0] m_top_value_reg;
    logic                    m_is_empty_reg;
    logic [CNT_W-1:0]        m_entry_count_reg;

    // pair RAM
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [PAIR_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [PAIR_W-1:0] mem_rd_data;

    uks_pair_t         rd_pair;
    uks_pair_t         wr_pair;
    logic [CW-1:0]     top_idx;
    logic              key_hit;
    logic              out_free;
    logic              out_load;
    logic [CW+CNT_W-1:0] fill_wide;

    uks_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pair_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign rd_pair       = uks_pair_t'(mem_rd_data);
    assign wr_pair.key   = key_reg;
    assign wr_pair.value = val_reg;
    assign top_idx       = fill_reg - CW'(1);

    // a stored key read last cycle matches the key being pushed
    assign key_hit = cmp_vld_reg && (rd_pair.key == key_reg);

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == S_DONE) && out_free;

    assign s_ready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_val_next    = res_val_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = fill_reg[AW-1:0];
        mem_wr_data = wr_pair;
        mem_rd_en   = 1'b0;
        mem_rd_addr = rd_idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    // capture the item and pick the path
                    act_next     = s_action;
                    key_next     = s_item_key;
                    val_next     = s_item_value;
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    unique case (s_action)
                        ACT_PUSH: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            // look, pop and the unused code
                            if (fill_reg == '0) begin
                                res_status_next = ST_EMPTY;
                                res_key_next    = '0;
                                res_val_next    = '0;
                                state_next      = S_DONE;
                            end else begin
                                res_status_next = ST_OK;
                                state_next      = S_TOP_RD;
                            end
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (key_hit) begin
                    // duplicate found: reject, report the current top
                    res_status_next = ST_DUP;
                    cmp_vld_next    = 1'b0;
                    state_next      = S_TOP_RD;
                end else if ((rd_idx_reg == fill_reg) && !cmp_vld_reg) begin
                    // every stored key compared, none matched
                    if (fill_reg == FILL_MAX) begin
                        res_status_next = ST_FULL;
                        state_next      = S_TOP_RD;
                    end else begin
                        mem_wr_en       = 1'b1;
                        fill_next       = fill_reg + CW'(1);
                        res_status_next = ST_OK;
                        res_key_next    = key_reg;
                        res_val_next    = val_reg;
                        state_next      = S_DONE;
                    end
                end else if (rd_idx_reg != fill_reg) begin
                    // issue the next key read
                    mem_rd_en    = 1'b1;
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                end else begin
                    // last read compared this cycle, drain
                    cmp_vld_next = 1'b0;
                end
            end

            S_TOP_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = top_idx[AW-1:0];
                if (act_reg == ACT_POP) begin
                    fill_next = top_idx;
                end
                state_next = S_TOP_WT;
            end

            S_TOP_WT: begin
                res_key_next = rd_pair.key;
                res_val_next = rd_pair.value;
                state_next   = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    assign fill_wide = {{CNT_W{1'b0}}, fill_next};

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_val_reg    <= res_val_next;
        if (out_load) begin
            // fill level is final by the time the sequencer reaches DONE
            m_status_reg      <= res_status_reg;
            m_top_key_reg     <= res_key_reg;
            m_top_value_reg   <= res_val_reg;
            m_is_empty_reg    <= (fill_reg == '0);
            m_entry_count_reg <= fill_wide[CNT_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_top_key     = m_top_key_reg;
    assign m_top_value   = m_top_value_reg;
    assign m_is_empty    = m_is_empty_reg;
    assign m_entry_count = m_entry_count_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef SYNTH
    a_fill_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill level above DEPTH");

    a_scan_idx : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (rd_idx_reg <= fill_reg))
        else $error("key scan ran past the fill level");

    a_wr_room : assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |=> (fill_reg == $past(fill_reg) + CW'(1)) && (state_reg == S_DONE))
        else $error("push write without a matching fill advance");

    a_dup_nonempty : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_DUP)) |-> !m_is_empty)
        else $error("duplicate reported on an empty stack");
`endif

endmodule

// ===== bench/uks_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uks_checker
// Watches both channels of the unique-key stack. It runs its own copy of the
// stack on every accepted item and compares each result item, field by field,
// with the oldest expected one.
// ----------------------------------------------------------------------------
module uks_checker
    import uks_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [1:0]              s_action,
    input  logic signed [KEY_W-1:0] s_item_key,
    input  logic signed [VAL_W-1:0] s_item_value,

    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [1:0]              m_status,
    input  logic signed [KEY_W-1:0] m_top_key,
    input  logic signed [VAL_W-1:0] m_top_value,
    input  logic                    m_is_empty,
    input  logic [CNT_W-1:0]        m_entry_count,

    output int                      fail_count,
    output int                      outstanding,
    output int                      results_checked,
    output int                      dup_seen,
    output int                      full_seen,
    output int                      empty_seen
);

    typedef struct {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
        logic                    empty;
        logic [CNT_W-1:0]        count;
    } stack_result_t;

    logic signed [KEY_W-1:0] stored_keys   [DEPTH];
    logic signed [VAL_W-1:0] stored_values [DEPTH];
    int                      depth_used;
    stack_result_t           pending_results [$];

    // Apply one item to the shadow stack and return the result it should give.
    function automatic stack_result_t next_stack_result(
        input logic [1:0]              act,
        input logic signed [KEY_W-1:0] k,
        input logic signed [VAL_W-1:0] v
    );
        stack_result_t r;
        logic          popped;
        logic          dup;
        r.status = ST_OK;
        r.key    = '0;
        r.value  = '0;
        popped   = 1'b0;
        dup      = 1'b0;
        case (act)
            ACT_PUSH: begin
                for (int i = 0; i < depth_used; i++)
                    if (stored_keys[i] == k)
                        dup = 1'b1;
                if (dup) begin
                    r.status = ST_DUP;
                end else if (depth_used >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stored_keys[depth_used]   = k;
                    stored_values[depth_used] = v;
                    depth_used++;
                end
            end
            ACT_POP: begin
                if (depth_used == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    depth_used--;
                    r.key   = stored_keys[depth_used];
                    r.value = stored_values[depth_used];
                    popped  = 1'b1;
                end
            end
            default: begin
                if (depth_used == 0)
                    r.status = ST_EMPTY;
            end
        endcase
        if (!popped && depth_used > 0) begin
            r.key   = stored_keys[depth_used - 1];
            r.value = stored_values[depth_used - 1];
        end
        r.empty = (depth_used == 0);
        r.count = CNT_W'(depth_used);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        stack_result_t want;
        if (!aresetn) begin
            pending_results.delete();
            depth_used      = 0;
            fail_count      = 0;
            results_checked = 0;
            dup_seen        = 0;
            full_seen       = 0;
            empty_seen      = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result item with no expected item waiting");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    results_checked++;
                    case (want.status)
                        ST_DUP:   dup_seen++;
                        ST_FULL:  full_seen++;
                        ST_EMPTY: empty_seen++;
                        default: ;
                    endcase
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        fail_count++;
                    end
                    if (m_top_key !== want.key) begin
                        $error("top_key: expected %0d, actual %0d", want.key, m_top_key);
                        fail_count++;
                    end
                    if (m_top_value !== want.value) begin
                        $error("top_value: expected %0d, actual %0d",
                               want.value, m_top_value);
                        fail_count++;
                    end
                    if (m_is_empty !== want.empty) begin
                        $error("is_empty: expected %0d, actual %0d", want.empty, m_is_empty);
                        fail_count++;
                    end
                    if (m_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.count, m_entry_count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(next_stack_result(s_action, s_item_key,
                                                            s_item_value));
        end
        outstanding <= pending_results.size();
    end

endmodule

// ===== bench/unique_key_stack_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_key_stack_test
// Drives look, push and pop items into the unique-key stack under several
// patterns of sender gaps and receiver stalls, and reports the verdict of the
// checker that sits beside the block.
// ----------------------------------------------------------------------------
module unique_key_stack_test
    import uks_pkg::*;
();

    localparam int         DEPTH            = 16;
    localparam int         RANDOM_PER_PHASE = 500;
    // the spare action code; the block treats it as a look
    localparam logic [1:0] ACT_SPARE        = 2'd3;

    typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED} episode_t;

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    s_valid      = 1'b0;
    logic [1:0]              s_action     = ACT_LOOK;
    logic signed [KEY_W-1:0] s_item_key   = '0;
    logic signed [VAL_W-1:0] s_item_value = '0;
    logic                    m_ready      = 1'b0;

    logic                    s_ready;
    logic                    m_valid;
    logic [1:0]              m_status;
    logic signed [KEY_W-1:0] m_top_key;
    logic signed [VAL_W-1:0] m_top_value;
    logic                    m_is_empty;
    logic [CNT_W-1:0]        m_entry_count;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    int fail_count;
    int outstanding;
    int results_checked;
    int dup_seen;
    int full_seen;
    int empty_seen;

    always #5 aclk = ~aclk;

    // Stall the result channel at random, at the rate of the current phase.
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    unique_key_stack #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_item_key   (s_item_key),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_top_key    (m_top_key),
        .m_top_value  (m_top_value),
        .m_is_empty   (m_is_empty),
        .m_entry_count(m_entry_count)
    );

    uks_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_item_key     (s_item_key),
        .s_item_value   (s_item_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_top_key      (m_top_key),
        .m_top_value    (m_top_value),
        .m_is_empty     (m_is_empty),
        .m_entry_count  (m_entry_count),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .results_checked(results_checked),
        .dup_seen       (dup_seen),
        .full_seen      (full_seen),
        .empty_seen     (empty_seen)
    );

    // Offer one item and hold it until accepted. Valid is only lowered for a
    // gap, so back-to-back items keep it high without a glitch.
    task automatic send_item(
        input logic [1:0]              act,
        input logic signed [KEY_W-1:0] k,
        input logic signed [VAL_W-1:0] v
    );
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_item_key   <= k;
        s_item_value <= v;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    // Drop valid and hold off until every expected result item has come.
    // The counter from the checker is registered, so sample after an edge.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (outstanding != 0);
    endtask

    // Keys: a small pool makes duplicates common, extremes hit the sign and
    // carry corners, the rest spread over the whole 32-bit range.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(9);
        if (roll < 4)
            return $signed(32'($urandom_range(23))) - 32'sd8;
        if (roll == 4) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Fill runs drive the stack to full, drain runs past empty; mixed runs
    // wander in between.
    function automatic logic [1:0] pick_action(input episode_t ep);
        int roll;
        roll = $urandom_range(99);
        case (ep)
            EP_FILL:  return (roll < 90) ? ACT_PUSH : ACT_LOOK;
            EP_DRAIN: return (roll < 88) ? ACT_POP : (roll < 94) ? ACT_LOOK : ACT_SPARE;
            default: begin
                if (roll < 45) return ACT_PUSH;
                if (roll < 80) return ACT_POP;
                if (roll < 93) return ACT_LOOK;
                return ACT_SPARE;
            end
        endcase
    endfunction

    // One phase of random runs at the given gap and stall rates, with one
    // pause halfway through until every expected result item has come.
    task automatic run_phase(input int gap_pct, input int stall_pct);
        int       sent;
        int       run_len;
        int       roll;
        logic     paused;
        episode_t ep;
        send_gap_pct = gap_pct;
        recv_stall_pct <= stall_pct;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_PER_PHASE) begin
            roll    = $urandom_range(9);
            ep      = (roll < 3) ? EP_FILL : (roll < 5) ? EP_DRAIN : EP_MIXED;
            run_len = $urandom_range(1, 20);
            repeat (run_len) begin
                if (sent < RANDOM_PER_PHASE) begin
                    send_item(pick_action(ep), pick_key(), $urandom);
                    sent++;
                end
            end
            if (!paused && sent >= RANDOM_PER_PHASE / 2) begin
                wait_idle();
                paused = 1'b1;
            end
        end
    endtask

    // Limit: the slowest correct run is about 2000 items, each through the
    // full key scan at worst, plus sender gaps and receiver stalls, and it
    // ends well before this watchdog.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        // hold reset low, then release it for good
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, no idling. Start with look, pop and the spare code
        // on an empty stack.
        send_item(ACT_LOOK, 32'sd0, 32'sd0);
        send_item(ACT_POP, 32'sd0, 32'sd0);
        send_item(ACT_SPARE, 32'sh7fff_ffff, 32'sh8000_0000);

        // Fill to the top: extremes first, then distinct patterns.
        send_item(ACT_PUSH, 32'sh8000_0000, 32'sh7fff_ffff);
        send_item(ACT_PUSH, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(ACT_PUSH, 32'sd0, 32'sd0);
        send_item(ACT_PUSH, -32'sd1, -32'sd1);
        for (int i = 4; i < DEPTH; i++)
            send_item(ACT_PUSH, 32'sh5a5a_0000 + i, ~(32'sh5a5a_0000 + i));

        // A new key on a full stack is refused as full; a repeated key on a
        // full stack is refused as a duplicate, since that check comes first.
        send_item(ACT_PUSH, 32'sh1234_5678, 32'sh0bad_cafe);
        send_item(ACT_PUSH, 32'sh8000_0000, 32'sd1);
        send_item(ACT_LOOK, 32'sd0, 32'sd0);
        send_item(ACT_SPARE, 32'sd0, 32'sd0);
        // pop the top, then push its key again: it is no longer held
        send_item(ACT_POP, 32'sd0, 32'sd0);
        send_item(ACT_PUSH, 32'sh5a5a_0000 + DEPTH - 1, 32'sh0f0f_0f0f);
        wait_idle();

        // Random part in four pressure phases.
        run_phase(0, 0);
        run_phase(63, 0);
        run_phase(0, 63);
        run_phase(23, 23);

        // let the block settle before the verdict
        wait_idle();
        repeat (40) @(posedge aclk);

        $display("Covered %0d items under four gap/stall phases; %0d results checked.",
                 items_sent, results_checked);
        $display("Rejections seen: %0d duplicate, %0d full, %0d empty.",
                 dup_seen, full_seen, empty_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/uks_pkg.sv
design/uks_ram.sv
design/unique_key_stack.sv
bench/uks_checker.sv
bench/unique_key_stack_test.sv
